FILE: src/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared constants, register map and key table for the pulse-distance IR
// decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

  // Configuration port geometry.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [1:0] REG_SHIFT_AMOUNT  = 2'd0;
  localparam logic [1:0] REG_REPEAT_VALUE  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [4:0]  SHIFT_RESET   = 5'd17;
  localparam logic [14:0] REPEAT_RESET  = 15'd58;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // Input opcodes.
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Stored samples saturate at this value.
  localparam int SAMPLE_W = 15;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 15'h7fff;

  // Remote key table: digits 0-9, enter, mute, last.
  localparam int KEY_COUNT = 13;
  localparam logic [3:0] NO_KEY = 4'd13;
  localparam logic [15:0] KEY_CODES [KEY_COUNT] = '{
    16'h08f7, 16'h8877, 16'h48b7, 16'hc837, 16'h28d7, 16'ha857, 16'h6897,
    16'he817, 16'h18e7, 16'h9867, 16'h22dd, 16'h906f, 16'h58a7
  };

  // Lowest table index whose code equals the given code, else NO_KEY.
  function automatic logic [3:0] match_key(input logic [31:0] c);
    logic [3:0] k;
    k = NO_KEY;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (c == {16'h0000, KEY_CODES[i]}) begin
        k = 4'(i);
      end
    end
    return k;
  endfunction

endpackage

FILE: src/irpd_ram.sv
// ----------------------------------------------------------------------------
// irpd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module irpd_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/ir_pulse_distance_decoder_core.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_core
// Pulse-distance infrared remote decoder: quantizes edge intervals, stores
// the samples of a frame and decodes a code, a key and a repeated-press flag.
// ----------------------------------------------------------------------------
// Usage:
// Input words carry an opcode (falling edge or one-millisecond tick) and the
// measured edge-to-edge interval. A tick, or an edge that neither completes a
// frame nor matches the repeat code, is taken in idle and gives no output.
// An edge that ends a frame or matches the repeat code yields one output
// word: the code is rebuilt from CODE_BITS stored samples by one shared
// shift-and-add unit, one slot per cycle behind the sample RAM's registered
// read; the next input is taken only once that word is loaded.
// in_ready is low while that accumulation runs. The output word sits in a
// register; if the receiver stalls, a finished word waits there and the
// decoder holds in its final step until the register frees, while ticks and
// silent edges keep being taken once it is back in idle.
// Reset clears the edge count, the press window and the previous code, and
// marks every sample slot as zero through per-slot valid bits, so the sample
// RAM needs no clearing pass. The user must write configuration registers
// through the APB port only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_core #(
  parameter int EDGES_PER_FRAME = 36,
  parameter int FIRST_BIT_SLOT  = 19,
  parameter int CODE_BITS       = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [irpd_pkg::ADDR_W-1:0] paddr,
  input  logic [irpd_pkg::DATA_W-1:0] pwdata,
  output logic [irpd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [31:0]                 interval_ticks,
  // Output channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 code,
  output logic [3:0]                  key_index,
  output logic                        repeated_press
);

  import irpd_pkg::*;

  localparam int AW = $clog2(EDGES_PER_FRAME);
  localparam int PW = $clog2(EDGES_PER_FRAME + 1);
  localparam int CW = $clog2(CODE_BITS + 1);
  localparam int SLOT_TOP = (FIRST_BIT_SLOT + CODE_BITS > EDGES_PER_FRAME) ?
                            (FIRST_BIT_SLOT + CODE_BITS) : EDGES_PER_FRAME;
  localparam int SW = $clog2(SLOT_TOP + 1);

  typedef enum logic [1:0] {IDLE, ACCUM, DONE} state_t;

  // Configuration registers.
  logic [4:0]  shift_amount;
  logic [14:0] repeat_value;
  logic [15:0] timeout_ticks;

  // Control state.
  state_t                     state;
  logic [PW-1:0]              edge_pos;      // edge count plus one
  logic [EDGES_PER_FRAME-1:0] slot_valid;
  logic [15:0]                window_remaining;
  logic                       window_running;
  logic                       expired_since_result;
  logic [31:0]                previous_code;
  logic                       previous_valid;
  logic [CW-1:0]              cnt;
  logic                       rd_ok;
  logic [31:0]                acc;

  // Datapath signals.
  logic                cfg_write;
  logic                in_fire;
  logic                edge_fire;
  logic [31:0]         quant;
  logic                is_repeat;
  logic                frame_end;
  logic [AW-1:0]       store_slot;
  logic [PW-1:0]       edge_pos_next;
  logic [SAMPLE_W-1:0] sample_sat;
  logic                wr_en;
  logic [SW-1:0]       rd_slot;
  logic                rd_in_range;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] rd_sample;
  logic [31:0]         acc_next;
  logic [3:0]          key_next;
  logic                rep_next;
  logic                out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      REG_SHIFT_AMOUNT:  prdata = {27'd0, shift_amount};
      REG_REPEAT_VALUE:  prdata = {17'd0, repeat_value};
      REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks};
      default:           prdata = '0;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount  <= SHIFT_RESET;
      repeat_value  <= REPEAT_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_SHIFT_AMOUNT:  shift_amount  <= pwdata[4:0];
        REG_REPEAT_VALUE:  repeat_value  <= pwdata[14:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = (state == IDLE);
  assign in_fire   = in_valid && in_ready;
  assign edge_fire = in_fire && (opcode == OP_EDGE);

  // Edge quantization, repeat detection and frame-end detection.
  always_comb begin
    quant      = interval_ticks >> shift_amount;
    is_repeat  = (quant == {17'd0, repeat_value});
    frame_end  = (edge_pos == PW'(EDGES_PER_FRAME));
    sample_sat = (quant > {17'd0, SAMPLE_MAX}) ? SAMPLE_MAX : quant[SAMPLE_W-1:0];
    if (frame_end) begin
      store_slot    = '0;
      edge_pos_next = PW'(1);
    end else begin
      store_slot    = edge_pos[AW-1:0];
      edge_pos_next = edge_pos + PW'(1);
    end
    if (is_repeat) begin
      edge_pos_next = '0;
    end
  end

  assign wr_en = edge_fire && !is_repeat;

  // Read side of the accumulation: slot for the current step.
  assign rd_slot     = SW'(FIRST_BIT_SLOT) + SW'(cnt);
  assign rd_in_range = (rd_slot < SW'(EDGES_PER_FRAME));
  assign rd_sample   = rd_ok ? rd_data : '0;
  assign acc_next    = {acc[30:0], 1'b0} + {17'd0, rd_sample};

  assign key_next = match_key(acc);
  assign rep_next = previous_valid && (previous_code == acc) && !expired_since_result;
  assign out_free = !out_valid || out_ready;

  irpd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (EDGES_PER_FRAME)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (store_slot),
    .wr_data (sample_sat),
    .rd_addr (rd_slot[AW-1:0]),
    .rd_data (rd_data)
  );

  // Sequencer, press window, previous code and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= IDLE;
      edge_pos             <= PW'(1);
      slot_valid           <= '0;
      window_remaining     <= '0;
      window_running       <= 1'b0;
      expired_since_result <= 1'b1;
      previous_code        <= '0;
      previous_valid       <= 1'b0;
      cnt                  <= '0;
      rd_ok                <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      rd_ok <= rd_in_range && slot_valid[rd_slot[AW-1:0]];
      // A taken word is cleared unless the final step loads a new one.
      if (out_valid && out_ready && state != DONE) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        slot_valid[store_slot] <= 1'b1;
      end
      unique case (state)
        IDLE: begin
          if (in_fire && opcode == OP_TICK) begin
            // A tick counts down a running press window.
            if (window_running) begin
              if (window_remaining <= 16'd1) begin
                window_remaining     <= '0;
                window_running       <= 1'b0;
                expired_since_result <= 1'b1;
              end else begin
                window_remaining <= window_remaining - 16'd1;
              end
            end
          end else if (edge_fire) begin
            edge_pos <= edge_pos_next;
            if (frame_end || is_repeat) begin
              cnt   <= '0;
              acc   <= '0;
              state <= ACCUM;
            end
          end
        end
        ACCUM: begin
          // One slot per cycle; read data arrives in the cycle after its address.
          if (cnt != '0) begin
            acc <= acc_next;
          end
          if (cnt == CW'(CODE_BITS)) begin
            state <= DONE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        DONE: begin
          if (out_free) begin
            code                 <= acc;
            key_index            <= key_next;
            repeated_press       <= rep_next;
            out_valid            <= 1'b1;
            previous_code        <= acc;
            previous_valid       <= 1'b1;
            expired_since_result <= 1'b0;
            window_remaining     <= timeout_ticks;
            window_running       <= 1'b1;
            state                <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
